### hw/rtl/mip_level_box_downsampler_core_defines.svh
// assertion macros for the mip level box downsampler
`ifndef MIP_LEVEL_BOX_DOWNSAMPLER_CORE_DEFINES_SVH
`define MIP_LEVEL_BOX_DOWNSAMPLER_CORE_DEFINES_SVH

// implication check with reset disable
`define MLB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication check with reset disable
`define MLB_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/mlb_pkg.sv
// shared types and constants for the mip level box downsampler
`timescale 1ns / 1ps
package mlb_pkg;
    localparam int CHAN_W = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 13;
    localparam int PROD_SUM_W = 35;
    localparam int ASUM_W = 18;
    localparam int DIV_CYC = 17;

    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LAYOUT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PREMUL = 2'd3;

    localparam logic [1:0] LAYOUT_GRAY = 2'd0;
    localparam logic [1:0] LAYOUT_GRAY_A = 2'd1;
    localparam logic [1:0] LAYOUT_RGB = 2'd2;
    localparam logic [1:0] LAYOUT_RGBA = 2'd3;

    localparam logic [1:0] PREMUL_OFF = 2'd0;
    localparam logic [1:0] PREMUL_MUL = 2'd1;

    localparam logic [PROD_SUM_W-1:0] PREMUL_DIV = 35'd262140;

    typedef struct packed {
        logic [CHAN_W-1:0] a;
        logic [CHAN_W-1:0] b;
        logic [CHAN_W-1:0] c;
        logic [CHAN_W-1:0] d;
    } t_pix;

    typedef struct packed {
        logic [CHAN_W-1:0] out_a;
        logic [CHAN_W-1:0] out_b;
        logic [CHAN_W-1:0] out_c;
        logic [CHAN_W-1:0] out_d;
        logic row_end;
        logic frame_end;
    } t_res;

    typedef struct packed {
        logic       has_alpha;
        logic       alpha_hi;
        logic       rgb;
        logic [1:0] mode;
        logic       row_end;
        logic       frame_end;
    } t_ctl;

    typedef enum logic [1:0] {
        ST_TAKE,
        ST_LOAD,
        ST_DIV,
        ST_SEND
    } t_state;
endpackage

### hw/rtl/mlb_if.sv
// valid/ready channel interfaces
`timescale 1ns / 1ps
interface mlb_pix_if;
    logic valid;
    logic ready;
    logic [mlb_pkg::CHAN_W-1:0] chan_a;
    logic [mlb_pkg::CHAN_W-1:0] chan_b;
    logic [mlb_pkg::CHAN_W-1:0] chan_c;
    logic [mlb_pkg::CHAN_W-1:0] chan_d;
    modport source (output valid, chan_a, chan_b, chan_c, chan_d, input ready);
    modport sink (input valid, chan_a, chan_b, chan_c, chan_d, output ready);
endinterface

interface mlb_res_if;
    logic valid;
    logic ready;
    logic [mlb_pkg::CHAN_W-1:0] out_a;
    logic [mlb_pkg::CHAN_W-1:0] out_b;
    logic [mlb_pkg::CHAN_W-1:0] out_c;
    logic [mlb_pkg::CHAN_W-1:0] out_d;
    logic row_end;
    logic frame_end;
    modport source (output valid, out_a, out_b, out_c, out_d, row_end, frame_end,
        input ready);
    modport sink (input valid, out_a, out_b, out_c, out_d, row_end, frame_end,
        output ready);
endinterface

interface mlb_cfg_if;
    logic valid;
    logic ready;
    logic [mlb_pkg::CFG_IDX_W-1:0] index;
    logic [mlb_pkg::CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### hw/rtl/mlb_lane.sv
// one colour lane: quad sum, premultiplied sum and serial divide
`timescale 1ns / 1ps
module mlb_lane (
    input  logic i_clk,
    input  logic i_load,
    input  logic i_step,
    input  logic [1:0] i_mode,
    input  logic i_use_alpha,
    input  logic [mlb_pkg::CHAN_W-1:0] i_c0,
    input  logic [mlb_pkg::CHAN_W-1:0] i_c1,
    input  logic [mlb_pkg::CHAN_W-1:0] i_c2,
    input  logic [mlb_pkg::CHAN_W-1:0] i_c3,
    input  logic [mlb_pkg::CHAN_W-1:0] i_a0,
    input  logic [mlb_pkg::CHAN_W-1:0] i_a1,
    input  logic [mlb_pkg::CHAN_W-1:0] i_a2,
    input  logic [mlb_pkg::CHAN_W-1:0] i_a3,
    input  logic [mlb_pkg::PROD_SUM_W-1:0] i_divisor,
    output logic [mlb_pkg::CHAN_W-1:0] o_value
);
    localparam int PW = mlb_pkg::PROD_SUM_W;
    localparam int CW = mlb_pkg::CHAN_W;

    logic [2*CW-1:0] r_p0, r_p1, r_p2, r_p3;
    logic [PW-1:0] r_rem;
    logic [CW-1:0] r_quo;
    logic [CW-1:0] r_plain;
    logic r_div_used;
    logic [PW-1:0] n_rem_sh;
    logic [PW-1:0] n_sum;
    logic [PW-1:0] n_top;
    logic [CW+1:0] n_plain;

    assign n_plain = {2'b00, i_c0} + {2'b00, i_c1} + {2'b00, i_c2} + {2'b00, i_c3};
    assign n_sum = {3'b000, r_p0} + {3'b000, r_p1} + {3'b000, r_p2} + {3'b000, r_p3};
    // quotient fits 16 bits: start with the high part already reduced
    assign n_top = n_sum >> CW;
    assign n_rem_sh = {r_rem[PW-2:0], r_quo[CW-1]};

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_p0 <= i_c0 * i_a0;
            r_p1 <= i_c1 * i_a1;
            r_p2 <= i_c2 * i_a2;
            r_p3 <= i_c3 * i_a3;
            r_plain <= n_plain[CW+1:2];
            r_div_used <= i_use_alpha && (i_mode != mlb_pkg::PREMUL_OFF);
            r_rem <= '0;
            r_quo <= '0;
        end else if (i_step) begin
            if (r_rem == '0 && r_quo == '0) begin
                r_rem <= n_top;
                r_quo <= n_sum[CW-1:0];
            end else if (n_rem_sh >= i_divisor) begin
                r_rem <= n_rem_sh - i_divisor;
                r_quo <= {r_quo[CW-2:0], 1'b1};
            end else begin
                r_rem <= n_rem_sh;
                r_quo <= {r_quo[CW-2:0], 1'b0};
            end
        end
    end

    assign o_value = !r_div_used ? r_plain : (i_divisor == '0) ? '0 : r_quo;
endmodule

### hw/rtl/mlb_merge.sv
// merges lane results with the alpha average into the output register
`timescale 1ns / 1ps
module mlb_merge (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_load,
    input  mlb_pkg::t_ctl i_ctl,
    input  logic [mlb_pkg::CHAN_W-1:0] i_lane0,
    input  logic [mlb_pkg::CHAN_W-1:0] i_lane1,
    input  logic [mlb_pkg::CHAN_W-1:0] i_lane2,
    input  logic [mlb_pkg::CHAN_W-1:0] i_alpha,
    input  logic i_ready,
    output logic o_valid,
    output mlb_pkg::t_res o_res
);
    mlb_pkg::t_res n_res;

    always_comb begin
        n_res = '0;
        n_res.out_a = i_lane0;
        n_res.row_end = i_ctl.row_end;
        n_res.frame_end = i_ctl.frame_end;
        if (i_ctl.rgb) begin
            n_res.out_b = i_lane1;
            n_res.out_c = i_lane2;
            if (i_ctl.has_alpha) n_res.out_d = i_alpha;
        end else if (i_ctl.has_alpha) begin
            n_res.out_b = i_alpha;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_load) begin
            o_valid <= 1'b1;
        end else if (i_ready) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) o_res <= n_res;
    end
endmodule

### hw/rtl/mip_level_box_downsampler_core.sv
// mip level box downsampler top level
// one 2x2 box-filter mip reduction over a raster stream of pixels of four 16-bit channels.
// channels: pix_in (valid/ready, four channels), res_out (valid/ready, four
// channels plus row_end and frame_end), cfg (index/data writes, idle only).
// a pixel that closes no quad is simply accepted. a quad-closing
// pixel passes through the load state, then the shared 16-step divide
// sequencer (three colour lanes in parallel), then waits in the output
// register; the next pixel is accepted once that beat is taken.
// plain average mode uses the same sequence.
// the even row is held in a line store of MAX_WIDTH entries, read at
// two addresses through registered ports.
// reset clears counters, state and registers to width 1, height 1, rgba,
// plain mode; the line store is not cleared. a stalled receiver holds the
// result and the block stops taking pixels until it drains.
`timescale 1ns / 1ps
`include "mip_level_box_downsampler_core_defines.svh"
module mip_level_box_downsampler_core #(
    parameter int MAX_WIDTH = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic i_clk,
    input  logic i_rst_n,
    mlb_pix_if.sink pix_in,
    mlb_res_if.source res_out,
    mlb_cfg_if.sink cfg
);
    localparam int CW = mlb_pkg::CHAN_W;
    localparam int XW = $clog2(MAX_WIDTH + 1);
    localparam int YW = $clog2(MAX_HEIGHT + 1);
    localparam int AW = $clog2(MAX_WIDTH);
    localparam int DW = mlb_pkg::CFG_DATA_W;
    localparam int SW = (XW > DW) ? XW : DW;
    localparam int TW = (YW > DW) ? YW : DW;

    mlb_pkg::t_state r_state, n_state;
    logic [DW-1:0] r_src_w, r_src_h;
    logic [1:0] r_layout, r_mode;
    logic [XW-1:0] r_col;
    logic [YW-1:0] r_row;
    logic [4:0] r_cnt;
    mlb_pkg::t_pix r_left, r_cur, r_q0, r_q1, r_q2, r_q3;
    logic [mlb_pkg::t_pix'($bits(mlb_pkg::t_pix))-1:0] r_mem [MAX_WIDTH];
    mlb_pkg::t_pix r_rd0, r_rd1;
    mlb_pkg::t_ctl r_ctl, n_ctl;
    logic r_use_mem;
    logic [mlb_pkg::ASUM_W-1:0] r_asum;
    logic [mlb_pkg::PROD_SUM_W-1:0] w_divisor;

    logic [XW-1:0] w_w, w_ow, w_x, w_x1;
    logic [YW-1:0] w_h, w_oh, w_y, w_y1;
    logic acc, emit, lane_load, lane_step, merge_load, res_valid;
    logic [CW-1:0] l0, l1, l2, alpha_avg;
    mlb_pkg::t_res res;
    mlb_pkg::t_pix in_pix, pa0, pa1, pa2, pa3;
    logic [CW-1:0] a0, a1, a2, a3;

    always_comb begin
        if (r_src_w == '0) w_w = XW'(1);
        else if (SW'(r_src_w) > SW'(MAX_WIDTH)) w_w = XW'(MAX_WIDTH);
        else w_w = XW'(r_src_w);
        if (r_src_h == '0) w_h = YW'(1);
        else if (TW'(r_src_h) > TW'(MAX_HEIGHT)) w_h = YW'(MAX_HEIGHT);
        else w_h = YW'(r_src_h);
        w_ow = (w_w >= XW'(2)) ? (w_w >> 1) : XW'(1);
        w_oh = (w_h >= YW'(2)) ? (w_h >> 1) : YW'(1);
        w_x = (r_col >= w_w) ? '0 : r_col;
        w_y = (r_row >= w_h) ? '0 : r_row;
        w_x1 = w_x + XW'(1);
        w_y1 = w_y + YW'(1);
    end

    assign in_pix = '{a: pix_in.chan_a, b: pix_in.chan_b, c: pix_in.chan_c,
        d: pix_in.chan_d};
    assign acc = pix_in.valid && pix_in.ready;
    assign pix_in.ready = (r_state == mlb_pkg::ST_TAKE);
    assign cfg.ready = 1'b1;

    always_comb begin
        emit = 1'b0;
        n_ctl = r_ctl;
        n_ctl.has_alpha = r_layout[0];
        n_ctl.alpha_hi = (r_layout == mlb_pkg::LAYOUT_RGBA);
        n_ctl.rgb = r_layout[1];
        n_ctl.mode = r_mode;
        n_ctl.row_end = 1'b0;
        n_ctl.frame_end = 1'b0;
        if (w_w == XW'(1) && w_h == YW'(1)) begin
            emit = 1'b1;
            n_ctl.row_end = 1'b1;
            n_ctl.frame_end = 1'b1;
        end else if (w_w == XW'(1)) begin
            if (w_y[0] && (w_y < (w_oh << 1))) begin
                emit = 1'b1;
                n_ctl.row_end = 1'b1;
                n_ctl.frame_end = ((w_y >> 1) == w_oh - YW'(1));
            end
        end else if (w_h == YW'(1)) begin
            if (w_x[0] && (w_x < (w_ow << 1))) begin
                emit = 1'b1;
                n_ctl.row_end = ((w_x >> 1) == w_ow - XW'(1));
                n_ctl.frame_end = n_ctl.row_end;
            end
        end else if (w_y[0] && (w_y < (w_oh << 1)) && w_x[0] && (w_x < (w_ow << 1))) begin
            emit = 1'b1;
            n_ctl.row_end = ((w_x >> 1) == w_ow - XW'(1));
            n_ctl.frame_end = n_ctl.row_end && ((w_y >> 1) == w_oh - YW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w <= DW'(1);
            r_src_h <= DW'(1);
            r_layout <= mlb_pkg::LAYOUT_RGBA;
            r_mode <= mlb_pkg::PREMUL_OFF;
        end else if (cfg.valid) begin
            case (cfg.index)
                mlb_pkg::REG_SRC_WIDTH: r_src_w <= cfg.data;
                mlb_pkg::REG_SRC_HEIGHT: r_src_h <= cfg.data;
                mlb_pkg::REG_LAYOUT: r_layout <= cfg.data[1:0];
                mlb_pkg::REG_PREMUL: r_mode <= cfg.data[1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_left <= '0;
        end else if (acc) begin
            if (w_x1 >= w_w) begin
                r_col <= '0;
                r_row <= (w_y1 >= w_h) ? '0 : w_y1;
            end else begin
                r_col <= w_x1;
                r_row <= w_y;
            end
            if (!w_x[0] && (w_h == YW'(1) || w_y[0])) r_left <= in_pix;
        end
    end

    // line store: write on even rows, two registered reads on quad close
    always_ff @(posedge i_clk) begin
        if (acc && !w_y[0]) begin
            if (w_w == XW'(1)) r_mem[0] <= in_pix;
            else r_mem[AW'(w_x)] <= in_pix;
        end
        if (acc && emit) begin
            r_rd0 <= r_mem[AW'(w_x - XW'(1))];
            r_rd1 <= r_mem[(w_w == XW'(1)) ? AW'(0) : AW'(w_x)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && emit) begin
            r_cur <= in_pix;
            r_ctl <= n_ctl;
            r_use_mem <= (w_h != YW'(1));
        end
    end

    // assemble quad: q0 top-left, q1 top-right, q2 bottom-left, q3 bottom-right
    always_comb begin
        pa3 = r_cur;
        if (!r_use_mem) begin
            pa1 = r_cur;
            pa0 = (w_w == XW'(1)) ? r_cur : r_left;
            pa2 = pa0;
        end else if (w_w == XW'(1)) begin
            pa0 = r_rd1;
            pa1 = r_rd1;
            pa2 = r_cur;
        end else begin
            pa0 = r_rd0;
            pa1 = r_rd1;
            pa2 = r_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == mlb_pkg::ST_LOAD) begin
            r_q0 <= pa0;
            r_q1 <= pa1;
            r_q2 <= pa2;
            r_q3 <= pa3;
        end
    end

    assign a0 = r_ctl.alpha_hi ? r_q0.d : r_q0.b;
    assign a1 = r_ctl.alpha_hi ? r_q1.d : r_q1.b;
    assign a2 = r_ctl.alpha_hi ? r_q2.d : r_q2.b;
    assign a3 = r_ctl.alpha_hi ? r_q3.d : r_q3.b;

    always_ff @(posedge i_clk) begin
        if (lane_load) begin
            r_asum <= {2'b00, a0} + {2'b00, a1} + {2'b00, a2} + {2'b00, a3};
        end
    end
    assign alpha_avg = r_asum[mlb_pkg::ASUM_W-1:2];
    assign w_divisor = (r_ctl.mode == mlb_pkg::PREMUL_MUL) ? mlb_pkg::PREMUL_DIV :
        mlb_pkg::PROD_SUM_W'(r_asum);

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            mlb_pkg::ST_TAKE: if (acc && emit) n_state = mlb_pkg::ST_LOAD;
            mlb_pkg::ST_LOAD: n_state = mlb_pkg::ST_DIV;
            mlb_pkg::ST_DIV: if (r_cnt == 5'(mlb_pkg::DIV_CYC + 1))
                n_state = mlb_pkg::ST_SEND;
            mlb_pkg::ST_SEND: if (!res_valid || res_out.ready) n_state = mlb_pkg::ST_TAKE;
            default: n_state = mlb_pkg::ST_TAKE;
        endcase
    end

    always_comb begin
        lane_load = 1'b0;
        lane_step = 1'b0;
        merge_load = 1'b0;
        case (r_state)
            mlb_pkg::ST_DIV: begin
                lane_load = (r_cnt == '0);
                lane_step = (r_cnt != '0);
                merge_load = (r_cnt == 5'(mlb_pkg::DIV_CYC + 1));
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mlb_pkg::ST_TAKE;
            r_cnt <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == mlb_pkg::ST_DIV) r_cnt <= r_cnt + 5'd1;
            else r_cnt <= '0;
        end
    end

    mlb_lane u_lane0 (.i_clk(i_clk), .i_load(lane_load), .i_step(lane_step),
        .i_mode(r_ctl.mode), .i_use_alpha(r_ctl.has_alpha),
        .i_c0(r_q0.a), .i_c1(r_q1.a), .i_c2(r_q2.a), .i_c3(r_q3.a),
        .i_a0(a0), .i_a1(a1), .i_a2(a2), .i_a3(a3),
        .i_divisor(w_divisor), .o_value(l0));
    mlb_lane u_lane1 (.i_clk(i_clk), .i_load(lane_load), .i_step(lane_step),
        .i_mode(r_ctl.mode), .i_use_alpha(r_ctl.has_alpha),
        .i_c0(r_q0.b), .i_c1(r_q1.b), .i_c2(r_q2.b), .i_c3(r_q3.b),
        .i_a0(a0), .i_a1(a1), .i_a2(a2), .i_a3(a3),
        .i_divisor(w_divisor), .o_value(l1));
    mlb_lane u_lane2 (.i_clk(i_clk), .i_load(lane_load), .i_step(lane_step),
        .i_mode(r_ctl.mode), .i_use_alpha(r_ctl.has_alpha),
        .i_c0(r_q0.c), .i_c1(r_q1.c), .i_c2(r_q2.c), .i_c3(r_q3.c),
        .i_a0(a0), .i_a1(a1), .i_a2(a2), .i_a3(a3),
        .i_divisor(w_divisor), .o_value(l2));

    mlb_merge u_merge (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_load(merge_load),
        .i_ctl(r_ctl), .i_lane0(l0), .i_lane1(l1), .i_lane2(l2), .i_alpha(alpha_avg),
        .i_ready(res_out.ready), .o_valid(res_valid), .o_res(res));

    assign res_out.valid = res_valid;
    assign res_out.out_a = res.out_a;
    assign res_out.out_b = res.out_b;
    assign res_out.out_c = res.out_c;
    assign res_out.out_d = res.out_d;
    assign res_out.row_end = res.row_end;
    assign res_out.frame_end = res.frame_end;

    `MLB_ASSERT_IMP(a_no_take_busy, i_clk, i_rst_n, r_state != mlb_pkg::ST_TAKE,
        !pix_in.ready, "pixel taken while busy")
    `MLB_ASSERT_NXT(a_close_loads, i_clk, i_rst_n, acc && emit,
        r_state == mlb_pkg::ST_LOAD, "quad close did not start sequence")
    `MLB_ASSERT_IMP(a_frame_row, i_clk, i_rst_n, res_valid && res.frame_end,
        res.row_end, "frame end without row end")
    `MLB_ASSERT_NXT(a_merge_valid, i_clk, i_rst_n, merge_load, res_valid,
        "merged result not valid")
endmodule

### dv/mip_level_box_downsampler_core_test.sv
// self-checking testbench for the mip level box downsampler core
`timescale 1ns / 1ps
module mip_level_box_downsampler_core_test;
    import mlb_pkg::*;

    localparam int MAX_W = 4096;
    localparam int MAX_H = 4096;
    localparam int LIMIT = 3000000;
    localparam int SETTLE = 60;

    logic i_clk;
    logic i_rst_n;
    mlb_pix_if pix ();
    mlb_res_if res ();
    mlb_cfg_if cfg ();

    mip_level_box_downsampler_core #(.MAX_WIDTH(MAX_W), .MAX_HEIGHT(MAX_H)) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .pix_in(pix),
        .res_out(res),
        .cfg(cfg)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    t_pix pixel_q[$];
    t_res quad_q[$];
    int errors = 0;
    int cycles = 0;
    int send_idle = 0;
    int recv_idle = 0;
    int hold_left = 0;

    // predictor state
    t_pix row_store[MAX_W];
    t_pix left_pix;
    int unsigned col_cnt, row_cnt;
    int unsigned cfg_w, cfg_h;
    logic [1:0] cfg_layout, cfg_mode;

    function automatic longint unsigned chan_of(t_pix p, int i);
        case (i)
            0: return p.a;
            1: return p.b;
            2: return p.c;
            default: return p.d;
        endcase
    endfunction

    function automatic int unsigned clamp_size(int unsigned v, int unsigned mx);
        if (v == 0) return 1;
        if (v > mx) return mx;
        return v;
    endfunction

    function automatic t_res box_filter(t_pix q[4]);
        logic [CHAN_W-1:0] o[4];
        bit alpha_on;
        int ai, ncol;
        longint unsigned asum, sum;
        t_res r;
        alpha_on = (cfg_layout == LAYOUT_GRAY_A) || (cfg_layout == LAYOUT_RGBA);
        ai = (cfg_layout == LAYOUT_RGBA) ? 3 : 1;
        ncol = (cfg_layout >= LAYOUT_RGB) ? 3 : 1;
        asum = 0;
        for (int i = 0; i < 4; i++) o[i] = '0;
        if (alpha_on) begin
            for (int k = 0; k < 4; k++) asum += chan_of(q[k], ai);
            o[ai] = asum >> 2;
        end
        for (int i = 0; i < ncol; i++) begin
            sum = 0;
            if (!alpha_on || cfg_mode == PREMUL_OFF) begin
                for (int k = 0; k < 4; k++) sum += chan_of(q[k], i);
                o[i] = sum >> 2;
            end else begin
                for (int k = 0; k < 4; k++) sum += chan_of(q[k], i) * chan_of(q[k], ai);
                if (cfg_mode == PREMUL_MUL) o[i] = sum / 64'd262140;
                else o[i] = (asum != 0) ? sum / asum : 0;
            end
        end
        r.out_a = o[0];
        r.out_b = o[1];
        r.out_c = o[2];
        r.out_d = o[3];
        r.row_end = 1'b0;
        r.frame_end = 1'b0;
        return r;
    endfunction

    function automatic void downsample_pixel(t_pix cur);
        int unsigned w, h, ow, oh, x, y, ox, oy;
        bit emit;
        t_pix q[4];
        t_res r;
        w = clamp_size(cfg_w, MAX_W);
        h = clamp_size(cfg_h, MAX_H);
        ow = (w >= 2) ? w / 2 : 1;
        oh = (h >= 2) ? h / 2 : 1;
        ox = 0;
        oy = 0;
        emit = 0;
        if (col_cnt >= w) col_cnt = 0;
        if (row_cnt >= h) row_cnt = 0;
        x = col_cnt;
        y = row_cnt;
        if (w == 1 && h == 1) begin
            q = '{cur, cur, cur, cur};
            emit = 1;
        end else if (w == 1) begin
            if (y[0] == 1'b0) begin
                row_store[0] = cur;
            end else if (y < 2 * oh) begin
                q = '{row_store[0], row_store[0], cur, cur};
                oy = y >> 1;
                emit = 1;
            end
        end else if (h == 1) begin
            if (x[0] == 1'b0) begin
                left_pix = cur;
            end else if (x < 2 * ow) begin
                q = '{left_pix, cur, left_pix, cur};
                ox = x >> 1;
                emit = 1;
            end
        end else begin
            if (y[0] == 1'b0) begin
                if (x < MAX_W) row_store[x] = cur;
            end else if (y < 2 * oh) begin
                if (x[0] == 1'b0) begin
                    left_pix = cur;
                end else if (x < 2 * ow && x < MAX_W) begin
                    q = '{row_store[x-1], row_store[x], left_pix, cur};
                    ox = x >> 1;
                    oy = y >> 1;
                    emit = 1;
                end
            end
        end
        col_cnt = x + 1;
        if (col_cnt >= w) begin
            col_cnt = 0;
            row_cnt = y + 1;
            if (row_cnt >= h) row_cnt = 0;
        end
        if (emit) begin
            r = box_filter(q);
            r.row_end = (ox == ow - 1);
            r.frame_end = r.row_end && (oy == oh - 1);
            quad_q.push_back(r);
        end
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix.valid <= 1'b0;
            pix.chan_a <= '0;
            pix.chan_b <= '0;
            pix.chan_c <= '0;
            pix.chan_d <= '0;
        end else begin
            if (pix.valid && pix.ready) begin
                downsample_pixel(pixel_q.pop_front());
            end
            if ((!pix.valid || pix.ready) && pixel_q.size() > 0 &&
                $urandom_range(99) >= send_idle) begin
                pix.valid <= 1'b1;
                pix.chan_a <= pixel_q[0].a;
                pix.chan_b <= pixel_q[0].b;
                pix.chan_c <= pixel_q[0].c;
                pix.chan_d <= pixel_q[0].d;
            end else if (!pix.valid || pix.ready) begin
                pix.valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_res want;
        if (!i_rst_n) begin
            res.ready <= 1'b0;
        end else begin
            if (res.valid && res.ready) begin
                if (quad_q.size() == 0) begin
                    report_mismatch("unexpected beat", 0, 0);
                end else begin
                    want = quad_q.pop_front();
                    if (res.out_a !== want.out_a) report_mismatch("out_a", res.out_a, want.out_a);
                    if (res.out_b !== want.out_b) report_mismatch("out_b", res.out_b, want.out_b);
                    if (res.out_c !== want.out_c) report_mismatch("out_c", res.out_c, want.out_c);
                    if (res.out_d !== want.out_d) report_mismatch("out_d", res.out_d, want.out_d);
                    if (res.row_end !== want.row_end)
                        report_mismatch("row_end", res.row_end, want.row_end);
                    if (res.frame_end !== want.frame_end)
                        report_mismatch("frame_end", res.frame_end, want.frame_end);
                end
            end
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                res.ready <= 1'b0;
            end else begin
                res.ready <= ($urandom_range(99) >= recv_idle);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    function automatic logic [CHAN_W-1:0] pick_chan();
        case ($urandom_range(3))
            0: return '0;
            1: return '1;
            default: return $urandom();
        endcase
    endfunction

    function automatic t_pix rand_pixel();
        t_pix p;
        p.a = pick_chan();
        p.b = pick_chan();
        p.c = pick_chan();
        p.d = pick_chan();
        return p;
    endfunction

    task automatic drain();
        do @(negedge i_clk); while (pixel_q.size() > 0 || pix.valid || quad_q.size() > 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_regs(int unsigned w, int unsigned h, logic [1:0] lay, logic [1:0] md);
        logic [CFG_DATA_W-1:0] vals[4];
        logic [CFG_IDX_W-1:0] idx[4];
        vals = '{w, h, lay, md};
        idx = '{REG_SRC_WIDTH, REG_SRC_HEIGHT, REG_LAYOUT, REG_PREMUL};
        @(posedge i_clk);
        for (int i = 0; i < 4; i++) begin
            cfg.valid <= 1'b1;
            cfg.index <= idx[i];
            cfg.data <= vals[i];
            do @(posedge i_clk); while (!cfg.ready);
            case (idx[i])
                REG_SRC_WIDTH: cfg_w = vals[i];
                REG_SRC_HEIGHT: cfg_h = vals[i];
                REG_LAYOUT: cfg_layout = vals[i][1:0];
                default: cfg_mode = vals[i][1:0];
            endcase
        end
        cfg.valid <= 1'b0;
    endtask

    task automatic run_frame(int unsigned w, int unsigned h, logic [1:0] lay, logic [1:0] md,
                             bit zero_alpha);
        int unsigned n;
        t_pix p;
        set_regs(w, h, lay, md);
        n = clamp_size(w, MAX_W) * clamp_size(h, MAX_H);
        for (int unsigned i = 0; i < n; i++) begin
            p = rand_pixel();
            if (zero_alpha) begin
                p.b = '0;
                p.d = '0;
            end
            pixel_q.push_back(p);
        end
        drain();
    endtask

    initial begin
        int phase;
        int unsigned sent;
        int unsigned w, h;
        t_pix p;
        i_rst_n = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data = '0;
        pix.valid = 1'b0;
        pix.chan_a = '0;
        pix.chan_b = '0;
        pix.chan_c = '0;
        pix.chan_d = '0;
        res.ready = 1'b0;
        col_cnt = 0;
        row_cnt = 0;
        left_pix = '0;
        cfg_w = 1;
        cfg_h = 1;
        cfg_layout = LAYOUT_RGBA;
        cfg_mode = PREMUL_OFF;
        for (int i = 0; i < MAX_W; i++) row_store[i] = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: every pixel is its own quad
        pixel_q.push_back('{16'h0000, 16'h0000, 16'h0000, 16'h0000});
        pixel_q.push_back('{16'hffff, 16'hffff, 16'hffff, 16'hffff});
        pixel_q.push_back('{16'hffff, 16'h0000, 16'hffff, 16'h0000});
        pixel_q.push_back('{16'h1234, 16'h5678, 16'h9abc, 16'hdef0});
        drain();
        run_frame(4, 4, LAYOUT_RGBA, PREMUL_MUL, 0);
        run_frame(1, 5, LAYOUT_GRAY_A, 2'd2, 0);
        run_frame(7, 1, LAYOUT_RGB, PREMUL_MUL, 0);
        run_frame(5, 3, LAYOUT_GRAY, PREMUL_OFF, 0);
        run_frame(2, 2, LAYOUT_RGBA, 2'd2, 1);
        run_frame(2, 2, LAYOUT_GRAY_A, 2'd3, 1);
        run_frame(0, 0, LAYOUT_RGBA, 2'd2, 0);

        // long receiver hold while the sender keeps offering
        set_regs(4, 2, LAYOUT_RGBA, 2'd3);
        hold_left = 400;
        for (int i = 0; i < 8; i++) pixel_q.push_back(rand_pixel());
        drain();

        // sender pauses mid-frame until every result is back
        set_regs(6, 4, LAYOUT_RGB, PREMUL_OFF);
        for (int i = 0; i < 12; i++) pixel_q.push_back(rand_pixel());
        drain();
        for (int i = 0; i < 12; i++) pixel_q.push_back(rand_pixel());
        drain();

        // saturated sizes
        run_frame(8191, 1, LAYOUT_RGBA, PREMUL_MUL, 0);
        run_frame(1, 8191, LAYOUT_GRAY_A, 2'd2, 0);
        run_frame(4100, 2, LAYOUT_RGBA, 2'd2, 0);

        sent = 0;
        phase = 0;
        while (sent < 1150) begin
            case (phase % 4)
                0: begin send_idle = 0; recv_idle = 0; end
                1: begin send_idle = 76; recv_idle = 0; end
                2: begin send_idle = 0; recv_idle = 76; end
                default: begin send_idle = 38; recv_idle = 38; end
            endcase
            w = ($urandom_range(9) == 0) ? $urandom_range(40, 1) : $urandom_range(12, 1);
            h = $urandom_range(8, 1);
            run_frame(w, h, $urandom_range(3), $urandom_range(3), ($urandom_range(15) == 0));
            sent += w * h;
            phase++;
        end

        // random pixels in an odd-sized frame that stops mid-frame
        set_regs(9, 5, LAYOUT_RGBA, 2'd2);
        send_idle = 20;
        recv_idle = 20;
        for (int i = 0; i < 30; i++) begin
            p = rand_pixel();
            pixel_q.push_back(p);
        end
        drain();

        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule
